FILE: rtl/rpn_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpn_pkg
// Shared command codes, status codes and control types.
// ---------------------------------------------------------------------------
package rpn_pkg;

    localparam logic [3:0] CMD_PUSH     = 4'd0;
    localparam logic [3:0] CMD_ADD      = 4'd1;
    localparam logic [3:0] CMD_SUB      = 4'd2;
    localparam logic [3:0] CMD_MUL      = 4'd3;
    localparam logic [3:0] CMD_DIV      = 4'd4;
    localparam logic [3:0] CMD_MOD      = 4'd5;
    localparam logic [3:0] CMD_POPPRINT = 4'd6;
    localparam logic [3:0] CMD_PEEK     = 4'd7;
    localparam logic [3:0] CMD_CLEAR    = 4'd8;
    localparam logic [3:0] CMD_DUP      = 4'd9;
    localparam logic [3:0] CMD_SWAP     = 4'd10;
    localparam logic [3:0] CMD_STORE    = 4'd11;
    localparam logic [3:0] CMD_LOAD     = 4'd12;
    localparam logic [3:0] CMD_RECALL   = 4'd13;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_DIVZERO   = 3'd3;
    localparam logic [2:0] ST_MODZERO   = 3'd4;
    localparam logic [2:0] ST_UNKNOWN   = 3'd5;

    // Divider request: unsigned magnitudes, 48-bit dividend, 32-bit divisor.
    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

endpackage

FILE: rtl/rpn_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpn_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rpn_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  rpn_pkg::div_req_t req,
    output rpn_pkg::div_rsp_t rsp
);

    logic        busy_reg;
    logic [5:0]  count_reg;
    logic [47:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] dvs_reg;
    logic        done_reg;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {rem_reg[31:0], quo_reg[47]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= 6'd47;
            end
            else if (busy_reg)
            begin
                if (count_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                count_reg <= count_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[46:0], 1'b0};
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[31:0];

endmodule

FILE: rtl/rpn_stack_calculator.sv
`timescale 1ns / 1ps
// Each word runs through the sequencer: pop operands, execute, push results,
// load the result register. Div and mod wait on the 48-step bit-serial
// divider; a divide or mod by zero stops the command early.
// Throughput: one word at a time; a stalled result holds the sequencer until
// the result register frees.
// Reset: asynchronous, active low; clears stack pointer, last printed value
// and variable valid bits. Stack memory is not cleared.
// ---------------------------------------------------------------------------
// rpn_stack_calculator
// RPN calculator on signed Q16.16 values. The value stack lives in a
// single-port synchronous memory; a sequencer pops operands, runs the
// operation and pushes results back.
// ---------------------------------------------------------------------------
module rpn_stack_calculator
#(
    parameter int STACK_DEPTH = 128,
    parameter int VAR_COUNT   = 26
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  cmd,
    input  logic signed [31:0] number,
    input  logic [4:0]  var_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        printed,
    output logic signed [31:0] print_value,
    output logic [2:0]  status,
    output logic [7:0]  depth
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int VW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_POPB  = 4'd1;  // issue read of top
    localparam logic [3:0] S_GETB  = 4'd2;  // capture top
    localparam logic [3:0] S_POPA  = 4'd3;
    localparam logic [3:0] S_GETA  = 4'd4;
    localparam logic [3:0] S_EXEC  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_DIVW  = 4'd7;
    localparam logic [3:0] S_PUSH1 = 4'd8;
    localparam logic [3:0] S_PUSH2 = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_MUL2  = 4'd11;

    logic [3:0]  state_reg;
    logic [3:0]  cmd_reg;
    logic [31:0] num_reg;
    logic [4:0]  vi_reg;
    logic [PW-1:0] sp_reg;
    logic [31:0] a_reg, b_reg;
    logic [31:0] res1_reg, res2_reg;
    logic        has1_reg, has2_reg;
    logic [2:0]  st_reg;
    logic        pr_reg;
    logic [31:0] pv_reg;
    logic [31:0] last_reg;
    logic        rd_pend_reg;
    logic        out_valid_reg;
    logic [63:0] prod_reg;
    logic        neg_reg;
    logic        div_mod_reg;
    logic        st_reg_i;

    // Stack memory, one port, registered read
    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] mem_q;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0] mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wd;
        mem_q <= mem[mem_addr];
    end

    // Variables: small register file with valid bits (reset reads as zero)
    logic [31:0] vars_reg [VAR_COUNT];
    logic [VAR_COUNT-1:0] vvalid_reg;
    logic        var_hit;
    logic [VW-1:0] var_sel;
    logic [31:0] var_rd;

    assign var_hit = ({27'd0, vi_reg} < 32'(VAR_COUNT));
    assign var_sel = VW'(vi_reg);
    assign var_rd  = (var_hit && vvalid_reg[var_sel]) ? vars_reg[var_sel] : 32'd0;

    // Divider
    rpn_pkg::div_req_t dreq;
    rpn_pkg::div_rsp_t drsp;

    rpn_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // Operand-count decode
    function automatic logic [1:0] pops_of(input logic [3:0] c);
        logic [1:0] n;
        begin
            n = 2'd0;
            unique case (c) inside
                rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL,
                rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD, rpn_pkg::CMD_SWAP: n = 2'd2;
                rpn_pkg::CMD_POPPRINT, rpn_pkg::CMD_PEEK,
                rpn_pkg::CMD_DUP, rpn_pkg::CMD_STORE:                  n = 2'd1;
                default:                                               n = 2'd0;
            endcase
            return n;
        end
    endfunction

    function automatic logic [31:0] sat33(input logic [32:0] x);
        begin
            if (x[32] != x[31])
                return x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            return x[31:0];
        end
    endfunction

    // Arithmetic helpers
    logic [32:0] sum33, dif33;
    logic signed [31:0] a_int, b_int;
    assign sum33 = {a_reg[31], a_reg} + {b_reg[31], b_reg};
    assign dif33 = {a_reg[31], a_reg} - {b_reg[31], b_reg};
    // integer parts truncated toward zero
    assign a_int = $signed(a_reg) >>> 16;
    assign b_int = $signed(b_reg) >>> 16;
    logic signed [31:0] a_tr, b_tr;
    assign a_tr = (a_reg[31] && a_reg[15:0] != 16'd0) ? a_int + 32'sd1 : a_int;
    assign b_tr = (b_reg[31] && b_reg[15:0] != 16'd0) ? b_int + 32'sd1 : b_int;

    // Divide and mod results with sign; the divide result also saturates
    logic [48:0] qsgn;
    logic [31:0] div_res, mod_res;
    logic [31:0] rem_s;
    assign qsgn = neg_reg ? (49'd0 - {1'b0, drsp.quotient}) : {1'b0, drsp.quotient};
    always_comb
    begin
        if (!neg_reg && drsp.quotient > 48'h0000_7FFF_FFFF)
            div_res = 32'h7FFF_FFFF;
        else if (neg_reg && drsp.quotient > 48'h0000_8000_0000)
            div_res = 32'h8000_0000;
        else
            div_res = qsgn[31:0];
        rem_s   = neg_reg ? (32'd0 - drsp.remainder) : drsp.remainder;
        mod_res = {rem_s[15:0], 16'd0};
    end

    logic [63:0] mul_sh;
    assign mul_sh = $signed(prod_reg) >>> 16;
    logic [31:0] mul_res;
    always_comb
    begin
        if (!mul_sh[63] && mul_sh[62:31] != 32'd0)
            mul_res = 32'h7FFF_FFFF;
        else if (mul_sh[63] && mul_sh[62:31] != 32'hFFFF_FFFF)
            mul_res = 32'h8000_0000;
        else
            mul_res = mul_sh[31:0];
    end

    logic [31:0] a_abs, b_abs, ai_abs, bi_abs;
    assign a_abs  = a_reg[31] ? 32'd0 - a_reg : a_reg;
    assign b_abs  = b_reg[31] ? 32'd0 - b_reg : b_reg;
    assign ai_abs = a_tr[31] ? 32'd0 - a_tr : a_tr;
    assign bi_abs = b_tr[31] ? 32'd0 - b_tr : b_tr;

    logic [1:0] npop;
    assign npop = pops_of(cmd_reg);

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            last_reg      <= '0;
            vvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            st_reg        <= rpn_pkg::ST_OK;
        end
        else
        begin
            // Raise valid as the result register loads; drop it once taken
            if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        st_reg    <= rpn_pkg::ST_OK;
                        state_reg <= S_POPB;
                    end
                end
                S_POPB:
                begin
                    // b is the first pop (the only one for single-pop commands)
                    if (npop == 2'd0)
                        state_reg <= S_EXEC;
                    else if (sp_reg == '0)
                    begin
                        st_reg    <= rpn_pkg::ST_UNDERFLOW;
                        b_reg     <= '0;
                        state_reg <= S_GETB;
                        rd_pend_reg <= 1'b0;
                    end
                    else
                    begin
                        sp_reg      <= sp_reg - 1'b1;
                        rd_pend_reg <= 1'b1;
                        state_reg   <= S_GETB;
                    end
                end
                S_GETB:
                begin
                    if (rd_pend_reg)
                        b_reg <= mem_q;
                    rd_pend_reg <= 1'b0;
                    state_reg   <= S_POPA;
                end
                S_POPA:
                begin
                    if (npop != 2'd2)
                    begin
                        a_reg     <= b_reg;
                        state_reg <= S_EXEC;
                    end
                    else if (cmd_reg == rpn_pkg::CMD_DIV && b_reg == 32'd0)
                    begin
                        st_reg    <= rpn_pkg::ST_DIVZERO;
                        state_reg <= S_DONE;
                    end
                    else if (cmd_reg == rpn_pkg::CMD_MOD && b_tr == 32'sd0)
                    begin
                        st_reg    <= rpn_pkg::ST_MODZERO;
                        state_reg <= S_DONE;
                    end
                    else if (sp_reg == '0)
                    begin
                        st_reg    <= rpn_pkg::ST_UNDERFLOW;
                        a_reg     <= '0;
                        state_reg <= S_GETA;
                    end
                    else
                    begin
                        sp_reg      <= sp_reg - 1'b1;
                        rd_pend_reg <= 1'b1;
                        state_reg   <= S_GETA;
                    end
                end
                S_GETA:
                begin
                    if (rd_pend_reg)
                        a_reg <= mem_q;
                    rd_pend_reg <= 1'b0;
                    state_reg   <= S_EXEC;
                end
                S_EXEC:
                begin
                    has1_reg  <= 1'b0;
                    has2_reg  <= 1'b0;
                    state_reg <= S_PUSH1;
                    unique case (cmd_reg)
                        rpn_pkg::CMD_PUSH:
                        begin
                            res1_reg <= num_reg; has1_reg <= 1'b1;
                        end
                        rpn_pkg::CMD_ADD:
                        begin
                            res1_reg <= sat33(sum33); has1_reg <= 1'b1;
                        end
                        rpn_pkg::CMD_SUB:
                        begin
                            res1_reg <= sat33(dif33); has1_reg <= 1'b1;
                        end
                        rpn_pkg::CMD_MUL:
                        begin
                            prod_reg  <= 64'($signed(a_reg) * $signed(b_reg));
                            state_reg <= S_MUL;
                        end
                        rpn_pkg::CMD_DIV:
                        begin
                            neg_reg     <= a_reg[31] ^ b_reg[31];
                            div_mod_reg <= 1'b0;
                            state_reg   <= S_DIVW;
                        end
                        rpn_pkg::CMD_MOD:
                        begin
                            neg_reg     <= a_tr[31];
                            div_mod_reg <= 1'b1;
                            state_reg   <= S_DIVW;
                        end
                        rpn_pkg::CMD_POPPRINT:
                        begin
                            pv_reg <= a_reg; last_reg <= a_reg;
                        end
                        rpn_pkg::CMD_PEEK:
                        begin
                            pv_reg <= a_reg;
                            res1_reg <= a_reg; has1_reg <= 1'b1;
                        end
                        rpn_pkg::CMD_CLEAR:
                            sp_reg <= '0;
                        rpn_pkg::CMD_DUP:
                        begin
                            res1_reg <= a_reg; res2_reg <= a_reg;
                            has1_reg <= 1'b1; has2_reg <= 1'b1;
                        end
                        rpn_pkg::CMD_SWAP:
                        begin
                            res1_reg <= b_reg; res2_reg <= a_reg;
                            has1_reg <= 1'b1; has2_reg <= 1'b1;
                        end
                        rpn_pkg::CMD_STORE:
                        begin
                            if (var_hit)
                            begin
                                vars_reg[var_sel]   <= a_reg;
                                vvalid_reg[var_sel] <= 1'b1;
                            end
                        end
                        rpn_pkg::CMD_LOAD:
                        begin
                            res1_reg <= var_rd; has1_reg <= 1'b1;
                        end
                        rpn_pkg::CMD_RECALL:
                        begin
                            res1_reg <= last_reg; has1_reg <= 1'b1;
                        end
                        default:
                            st_reg <= rpn_pkg::ST_UNKNOWN;
                    endcase
                end
                S_MUL:
                    state_reg <= S_MUL2;
                S_MUL2:
                begin
                    res1_reg  <= mul_res;
                    has1_reg  <= 1'b1;
                    state_reg <= S_PUSH1;
                end
                S_DIVW:
                begin
                    if (drsp.done)
                    begin
                        res1_reg  <= div_mod_reg ? mod_res : div_res;
                        has1_reg  <= 1'b1;
                        state_reg <= S_PUSH1;
                    end
                end
                S_PUSH1:
                begin
                    if (has1_reg)
                    begin
                        if (sp_reg >= PW'(STACK_DEPTH))
                            st_reg <= rpn_pkg::ST_OVERFLOW;
                        else
                            sp_reg <= sp_reg + 1'b1;
                    end
                    state_reg <= S_PUSH2;
                end
                S_PUSH2:
                begin
                    if (has2_reg)
                    begin
                        if (sp_reg >= PW'(STACK_DEPTH))
                            st_reg <= rpn_pkg::ST_OVERFLOW;
                        else
                            sp_reg <= sp_reg + 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // Hold here while the previous result still waits
                    if (!out_valid_reg || !out_stall)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Input capture; flag the first cycle of a word
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && !in_stall)
        begin
            cmd_reg  <= cmd;
            num_reg  <= number;
            vi_reg   <= var_index;
            st_reg_i <= 1'b1;
        end
        else
            st_reg_i <= 1'b0;
    end

    // Result register
    logic [2:0]  o_st_reg;
    logic        o_pr_reg;
    logic [31:0] o_pv_reg;
    logic [7:0]  o_dp_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
        begin
            o_st_reg <= st_reg;
            o_pr_reg <= pr_reg;
            o_pv_reg <= pr_reg ? pv_reg : 32'd0;
            o_dp_reg <= 8'(sp_reg);
        end
    end

    // Memory port control
    always_comb
    begin
        mem_we   = 1'b0;
        mem_wd   = res1_reg;
        mem_addr = AW'(sp_reg - 1'b1);
        if (state_reg == S_POPB || state_reg == S_POPA)
            mem_addr = AW'(sp_reg - 1'b1);
        else if (state_reg == S_PUSH1)
        begin
            mem_addr = AW'(sp_reg);
            mem_we   = has1_reg && (sp_reg < PW'(STACK_DEPTH));
            mem_wd   = res1_reg;
        end
        else if (state_reg == S_PUSH2)
        begin
            mem_addr = AW'(sp_reg);
            mem_we   = has2_reg && (sp_reg < PW'(STACK_DEPTH));
            mem_wd   = res2_reg;
        end
    end

    // Divider launch
    always_comb
    begin
        dreq.start    = (state_reg == S_EXEC) &&
                        (cmd_reg == rpn_pkg::CMD_DIV || cmd_reg == rpn_pkg::CMD_MOD);
        dreq.dividend = (cmd_reg == rpn_pkg::CMD_MOD) ? {16'd0, ai_abs}
                                                      : {a_abs, 16'd0};
        dreq.divisor  = (cmd_reg == rpn_pkg::CMD_MOD) ? bi_abs : b_abs;
    end

    // Clear the print flag at word start; set it for popprint and peek
    always_ff @(posedge clk)
    begin
        if (st_reg_i)
        begin
            pr_reg <= 1'b0;
        end
        else if (state_reg == S_EXEC &&
                 (cmd_reg == rpn_pkg::CMD_POPPRINT || cmd_reg == rpn_pkg::CMD_PEEK))
            pr_reg <= 1'b1;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign printed     = o_pr_reg;
    assign print_value = o_pv_reg;
    assign status      = o_st_reg;
    assign depth       = o_dp_reg;

endmodule
